>>> src/tlpm_pkg.sv
`default_nettype none

package tlpm_pkg;

  localparam int NODE_COUNT_DEF  = 256;
  localparam int AGENT_COUNT_DEF = 256;

  localparam int CHAR_W     = 8;
  localparam int AGENT_ID_W = 8;
  localparam int LENGTH_W   = 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_ROUTE  = 1'b1;

  localparam logic [LENGTH_W-1:0] DEPTH_MAX = '1;

  localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic clear;
    logic capture;
    logic node_read;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic last;
    logic out_free;
  } status_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/tlpm_ctrl.sv
`default_nettype none

module tlpm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output tlpm_pkg::cmd_t         cmd,
  input  wire tlpm_pkg::status_t status
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_NODE,
    S_UPDATE
  } state_t;

  state_t state;

  always_comb begin
    cmd.clear     = (state == S_CLEAR);
    cmd.capture   = in_valid && in_ready;
    cmd.node_read = (state == S_NODE);
    cmd.update    = (state == S_UPDATE) && (!status.last || status.out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      in_ready <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (status.clear_last) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_NODE;
            in_ready <= 1'b0;
          end
        end
        S_NODE: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (cmd.update) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_CLEAR;
          in_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/tlpm_datapath.sv
`default_nettype none

module tlpm_datapath #(
  parameter int NODE_COUNT  = tlpm_pkg::NODE_COUNT_DEF,
  parameter int AGENT_COUNT = tlpm_pkg::AGENT_COUNT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tlpm_pkg::cmd_t                      cmd,
  output tlpm_pkg::status_t                        status,
  input  wire logic                                operation,
  input  wire logic [tlpm_pkg::CHAR_W-1:0]         character,
  input  wire logic                                last,
  input  wire logic [tlpm_pkg::AGENT_ID_W-1:0]     agent_id,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic                                     op_done,
  output logic                                     found,
  output logic [tlpm_pkg::LENGTH_W-1:0]            matched_length,
  output logic [tlpm_pkg::AGENT_ID_W-1:0]          agent_result,
  output logic                                     table_full
);

  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int LINK_DEPTH = NODE_COUNT * (2 ** tlpm_pkg::CHAR_W);
  localparam int LINK_AW    = NODE_W + tlpm_pkg::CHAR_W;
  localparam int USED_W     = NODE_W + 1;
  localparam int AGENT_W    = (AGENT_COUNT >= 2 ** tlpm_pkg::AGENT_ID_W) ?
                              tlpm_pkg::AGENT_ID_W : $clog2(AGENT_COUNT);
  localparam int AGENT_VALS = 2 ** tlpm_pkg::AGENT_ID_W;

  logic [NODE_W-1:0]  link_mem  [LINK_DEPTH];
  logic               end_mem   [NODE_COUNT];
  logic [AGENT_W-1:0] agent_mem [NODE_COUNT];

  logic [AGENT_W-1:0] agent_mod_tbl [AGENT_VALS];

  for (genvar g = 0; g < AGENT_VALS; g++) begin : g_agent_mod
    assign agent_mod_tbl[g] = AGENT_W'(g % AGENT_COUNT);
  end

  logic                              op_q;
  logic                              last_q;
  logic [tlpm_pkg::CHAR_W-1:0]       char_q;
  logic [tlpm_pkg::AGENT_ID_W-1:0]   agent_q;
  logic [NODE_W-1:0]                 child_q;
  logic                              end_rd;
  logic [AGENT_W-1:0]                agent_rd;

  logic [LINK_AW-1:0]                clr_addr;
  logic [USED_W-1:0]                 nodes_used;
  logic [NODE_W-1:0]                 walk_node;
  logic                              walk_stopped;
  logic [tlpm_pkg::LENGTH_W-1:0]     walk_depth;
  logic [tlpm_pkg::LENGTH_W-1:0]     best_length;
  logic [AGENT_W-1:0]                best_agent;
  logic                              insert_failed;

  logic                              is_child;
  logic                              alloc;
  logic [NODE_W-1:0]                 walk_node_next;
  logic                              walk_stopped_next;
  logic [tlpm_pkg::LENGTH_W-1:0]     walk_depth_next;
  logic [tlpm_pkg::LENGTH_W-1:0]     best_length_next;
  logic [AGENT_W-1:0]                best_agent_next;
  logic                              insert_failed_next;

  logic                              link_we;
  logic [LINK_AW-1:0]                link_waddr;
  logic [NODE_W-1:0]                 link_wdata;
  logic [LINK_AW-1:0]                link_raddr;
  logic                              node_we;
  logic                              agent_we;
  logic [AGENT_W-1:0]                agent_mod;

  always_comb begin
    is_child           = (child_q != '0);
    alloc              = 1'b0;
    walk_node_next     = walk_node;
    walk_stopped_next  = walk_stopped;
    walk_depth_next    = walk_depth;
    best_length_next   = best_length;
    best_agent_next    = best_agent;
    insert_failed_next = insert_failed;
    if (op_q == tlpm_pkg::OP_INSERT) begin
      if (!insert_failed) begin
        if (is_child) begin
          walk_node_next = child_q;
        end else if (nodes_used < USED_W'(NODE_COUNT)) begin
          alloc          = 1'b1;
          walk_node_next = nodes_used[NODE_W-1:0];
        end else begin
          insert_failed_next = 1'b1;
        end
      end
    end else if (op_q == tlpm_pkg::OP_ROUTE && !walk_stopped) begin
      if (!is_child) begin
        walk_stopped_next = 1'b1;
      end else begin
        walk_node_next = child_q;
        if (walk_depth != tlpm_pkg::DEPTH_MAX) begin
          walk_depth_next = walk_depth + 1'b1;
        end
        if (end_rd) begin
          best_length_next = walk_depth_next;
          best_agent_next  = agent_rd;
        end
      end
    end
  end

  always_comb begin
    link_raddr = {walk_node, tlpm_pkg::fold_case(character)};
    link_we    = cmd.clear || (cmd.update && alloc);
    link_waddr = cmd.clear ? clr_addr : {walk_node, char_q};
    link_wdata = cmd.clear ? '0 : walk_node_next;
    node_we    = cmd.update && (op_q == tlpm_pkg::OP_INSERT) && !insert_failed_next &&
                 (alloc || last_q);
    agent_we   = node_we && last_q;
    agent_mod  = agent_mod_tbl[agent_q];
  end

  always_comb begin
    status.clear_last = (clr_addr == LINK_AW'(LINK_DEPTH - 1));
    status.last       = last_q;
    status.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (cmd.capture) begin
      child_q <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      end_mem[walk_node_next] <= last_q;
    end
    if (agent_we) begin
      agent_mem[walk_node_next] <= agent_mod;
    end
    if (cmd.node_read) begin
      end_rd   <= end_mem[child_q];
      agent_rd <= agent_mem[child_q];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= operation;
      last_q  <= last;
      char_q  <= tlpm_pkg::fold_case(character);
      agent_q <= agent_id;
    end
    if (cmd.update && last_q) begin
      op_done <= op_q;
      if (op_q == tlpm_pkg::OP_INSERT) begin
        found          <= 1'b0;
        matched_length <= '0;
        agent_result   <= '0;
        table_full     <= insert_failed_next;
      end else begin
        found          <= (best_length_next != '0);
        matched_length <= best_length_next;
        agent_result   <= tlpm_pkg::AGENT_ID_W'(best_agent_next);
        table_full     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr      <= '0;
      nodes_used    <= USED_W'(1);
      walk_node     <= '0;
      walk_stopped  <= 1'b0;
      walk_depth    <= '0;
      best_length   <= '0;
      best_agent    <= '0;
      insert_failed <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.update) begin
        if (alloc) begin
          nodes_used <= nodes_used + 1'b1;
        end
        if (last_q) begin
          walk_node     <= '0;
          walk_stopped  <= 1'b0;
          walk_depth    <= '0;
          best_length   <= '0;
          best_agent    <= '0;
          insert_failed <= 1'b0;
        end else begin
          walk_node     <= walk_node_next;
          walk_stopped  <= walk_stopped_next;
          walk_depth    <= walk_depth_next;
          best_length   <= best_length_next;
          best_agent    <= best_agent_next;
          insert_failed <= insert_failed_next;
        end
      end
      if (cmd.update && last_q) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/trie_longest_prefix_match.sv
// Character trie with longest-prefix lookup, fed one key byte per request.
// Input channel (in_valid/in_ready): operation (0 insert, 1 route), character,
// last and agent_id. Letters A-Z fold to lowercase. A key or query ends on the
// request with last set; only that request produces a result.
// Output channel (out_valid/out_ready): op_done, found, matched_length,
// agent_result and table_full, held in an output register.
// Each byte takes a link memory read at the accepting edge, then a read of the
// child's end mark and agent, then the walk update, which registers the result
// of a last byte. A new byte is taken only after the walk update of the one
// before; the two memory reads are dependent, the second using the first.
// Reset clears the walk and the node pool, then sweeps the link memory one
// entry per cycle, NODE_COUNT * 256 entries (65536 by default), with in_ready
// low. If the output register still holds an untaken result, a last byte
// waits in its final step until out_ready frees the register; other bytes
// proceed regardless of the receiver.
`default_nettype none

module trie_longest_prefix_match #(
  parameter int NODE_COUNT  = tlpm_pkg::NODE_COUNT_DEF,
  parameter int AGENT_COUNT = tlpm_pkg::AGENT_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            operation,
  input  wire logic [tlpm_pkg::CHAR_W-1:0]     character,
  input  wire logic                            last,
  input  wire logic [tlpm_pkg::AGENT_ID_W-1:0] agent_id,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 op_done,
  output logic                                 found,
  output logic [tlpm_pkg::LENGTH_W-1:0]        matched_length,
  output logic [tlpm_pkg::AGENT_ID_W-1:0]      agent_result,
  output logic                                 table_full
);

  tlpm_pkg::cmd_t    cmd;
  tlpm_pkg::status_t status;

  tlpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  tlpm_datapath #(
    .NODE_COUNT  (NODE_COUNT),
    .AGENT_COUNT (AGENT_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .operation      (operation),
    .character      (character),
    .last           (last),
    .agent_id       (agent_id),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .op_done        (op_done),
    .found          (found),
    .matched_length (matched_length),
    .agent_result   (agent_result),
    .table_full     (table_full)
  );

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(cmd.update && status.last))
    else $error("result appeared without a final update");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && status.last) |-> status.out_free)
    else $error("final update while output register is occupied");

  a_no_request_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !in_ready)
    else $error("request taken during link memory sweep");

  a_capture_then_read: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (cmd.node_read && !in_ready))
    else $error("accepted request not followed by node read");

endmodule

`default_nettype wire

>>> bench/trie_longest_prefix_match_tb.sv
`default_nettype none

module trie_longest_prefix_match_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_COUNT  = tlpm_pkg::NODE_COUNT_DEF;
  localparam int AGENT_COUNT = tlpm_pkg::AGENT_COUNT_DEF;
  localparam int IDLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {
    WORD_PLAIN,
    WORD_MIXED
  } word_style_t;

  typedef struct packed {
    logic                            op_done;
    logic                            found;
    logic [tlpm_pkg::LENGTH_W-1:0]   matched_length;
    logic [tlpm_pkg::AGENT_ID_W-1:0] agent_result;
    logic                            table_full;
  } answer_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  logic                            operation;
  logic [tlpm_pkg::CHAR_W-1:0]     character;
  logic                            last;
  logic [tlpm_pkg::AGENT_ID_W-1:0] agent_id;
  logic                            out_valid;
  logic                            out_ready;
  logic                            op_done;
  logic                            found;
  logic [tlpm_pkg::LENGTH_W-1:0]   matched_length;
  logic [tlpm_pkg::AGENT_ID_W-1:0] agent_result;
  logic                            table_full;

  trie_longest_prefix_match dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .character     (character),
    .last          (last),
    .agent_id      (agent_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .op_done       (op_done),
    .found         (found),
    .matched_length(matched_length),
    .agent_result  (agent_result),
    .table_full    (table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // trie shadow state
  int                              trie_links [NODE_COUNT*256];
  bit                              key_end [NODE_COUNT];
  bit [tlpm_pkg::AGENT_ID_W-1:0]   key_agent [NODE_COUNT];
  int                              nodes_taken = 1;
  int                              walk_node = 0;
  bit                              walk_stopped = 1'b0;
  int                              walk_depth = 0;
  int                              best_length = 0;
  bit [tlpm_pkg::AGENT_ID_W-1:0]   best_agent = '0;
  bit                              insert_failed = 1'b0;

  answer_t pending_answers [$];
  int      mismatch_count = 0;
  int      requests_sent = 0;
  int      idle_cycles = 0;
  bit      stalls_on = 1'b1;
  int      ready_hold = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!stalls_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic walk_trie_byte(input logic op, input logic [tlpm_pkg::CHAR_W-1:0] ch,
                                input logic lst, input logic [tlpm_pkg::AGENT_ID_W-1:0] ag);
    logic [tlpm_pkg::CHAR_W-1:0] c;
    int                          slot;
    int                          child;
    answer_t                     a;
    c = ch;
    if (c >= tlpm_pkg::UPPER_FIRST && c <= tlpm_pkg::UPPER_LAST) c = c + tlpm_pkg::CASE_OFFSET;
    slot = walk_node * 256 + int'(c);
    if (op == tlpm_pkg::OP_INSERT) begin
      if (!insert_failed) begin
        child = trie_links[slot];
        if (child == 0) begin
          if (nodes_taken < NODE_COUNT) begin
            child = nodes_taken;
            nodes_taken++;
            trie_links[slot] = child;
          end else begin
            insert_failed = 1'b1;
          end
        end
        if (!insert_failed) walk_node = child;
      end
    end else if (!walk_stopped) begin
      child = trie_links[slot];
      if (child == 0) begin
        walk_stopped = 1'b1;
      end else begin
        walk_node = child;
        if (walk_depth < 255) walk_depth++;
        if (key_end[child]) begin
          best_length = walk_depth;
          best_agent = key_agent[child];
        end
      end
    end
    if (lst) begin
      a = '0;
      if (op == tlpm_pkg::OP_INSERT) begin
        if (!insert_failed) begin
          key_end[walk_node] = 1'b1;
          key_agent[walk_node] = tlpm_pkg::AGENT_ID_W'(int'(ag) % AGENT_COUNT);
        end
        a.op_done = tlpm_pkg::OP_INSERT;
        a.table_full = insert_failed;
      end else begin
        a.op_done = tlpm_pkg::OP_ROUTE;
        a.found = (best_length != 0);
        a.matched_length = tlpm_pkg::LENGTH_W'(best_length);
        a.agent_result = best_agent;
      end
      pending_answers.push_back(a);
      walk_node = 0;
      walk_stopped = 1'b0;
      walk_depth = 0;
      best_length = 0;
      best_agent = '0;
      insert_failed = 1'b0;
    end
  endtask

  task automatic send_request(input logic op, input logic [tlpm_pkg::CHAR_W-1:0] ch,
                              input logic lst, input logic [tlpm_pkg::AGENT_ID_W-1:0] ag);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    character <= ch;
    last      <= lst;
    agent_id  <= ag;
    do @(posedge clk); while (!in_ready);
    walk_trie_byte(op, ch, lst, ag);
    requests_sent++;
  endtask

  task automatic send_text(input logic op, input string s,
                           input logic [tlpm_pkg::AGENT_ID_W-1:0] ag);
    for (int i = 0; i < s.len(); i++) begin
      if (i == s.len() - 1) send_request(op, s[i], 1'b1, ag);
      else send_request(op, s[i], 1'b0, tlpm_pkg::AGENT_ID_W'($urandom_range(0, 255)));
    end
  endtask

  function automatic logic [tlpm_pkg::CHAR_W-1:0] pick_char(input bit wide);
    logic [tlpm_pkg::CHAR_W-1:0] c;
    if (wide ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 19) == 0))
      return tlpm_pkg::CHAR_W'($urandom_range(0, 255));
    c = 8'h61 + tlpm_pkg::CHAR_W'($urandom_range(0, 2));
    if ($urandom_range(0, 1) == 1) c = c - tlpm_pkg::CASE_OFFSET;
    return c;
  endfunction

  task automatic send_word(input word_style_t style, input bit wide);
    logic op;
    int   len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
    op = ($urandom_range(0, 9) < 4) ? tlpm_pkg::OP_INSERT : tlpm_pkg::OP_ROUTE;
    for (int i = 0; i < len; i++) begin
      if (style == WORD_MIXED) op = 1'($urandom_range(0, 1));
      send_request(op, pick_char(wide), i == len - 1,
                   tlpm_pkg::AGENT_ID_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_directed();
    stalls_on = 1'b1;
    send_text(tlpm_pkg::OP_ROUTE, "a", 8'h00);
    send_text(tlpm_pkg::OP_INSERT, "A", 8'hFF);
    send_text(tlpm_pkg::OP_ROUTE, "a", 8'h00);
    send_text(tlpm_pkg::OP_INSERT, "ab", 8'h00);
    send_text(tlpm_pkg::OP_ROUTE, "ABZ", 8'h00);
    send_text(tlpm_pkg::OP_INSERT, "a", 8'h5A);
    send_text(tlpm_pkg::OP_ROUTE, "a", 8'h00);
    send_request(tlpm_pkg::OP_INSERT, 8'h00, 1'b0, 8'hFF);
    send_request(tlpm_pkg::OP_INSERT, 8'hFF, 1'b1, 8'h80);
    send_request(tlpm_pkg::OP_ROUTE, 8'h00, 1'b0, 8'h00);
    send_request(tlpm_pkg::OP_ROUTE, 8'hFF, 1'b0, 8'hFF);
    send_request(tlpm_pkg::OP_ROUTE, 8'hFF, 1'b1, 8'h00);
    send_request(tlpm_pkg::OP_INSERT, "c", 1'b0, 8'h11);
    send_request(tlpm_pkg::OP_ROUTE, "a", 1'b1, 8'h22);
    send_request(tlpm_pkg::OP_ROUTE, "a", 1'b0, 8'h33);
    send_request(tlpm_pkg::OP_INSERT, "q", 1'b1, 8'h07);
    send_text(tlpm_pkg::OP_ROUTE, "aq", 8'h00);
    send_request(tlpm_pkg::OP_INSERT, 8'h40, 1'b0, 8'h01);
    send_request(tlpm_pkg::OP_INSERT, 8'h5B, 1'b0, 8'h01);
    send_request(tlpm_pkg::OP_INSERT, 8'h60, 1'b0, 8'h01);
    send_request(tlpm_pkg::OP_INSERT, 8'h7B, 1'b1, 8'h01);
  endtask

  task automatic test_random_words();
    int target;
    target = requests_sent + 150;
    while (requests_sent < target) begin
      if ($urandom_range(0, 19) == 0) stalls_on = ($urandom_range(0, 3) != 0);
      send_word(($urandom_range(0, 9) == 0) ? WORD_MIXED : WORD_PLAIN, 1'b0);
    end
    stalls_on = 1'b1;
  endtask

  task automatic test_pool_exhaustion();
    int room;
    room = NODE_COUNT - nodes_taken;
    if (room < 1) room = 1;
    for (int i = 0; i < room; i++)
      send_request(tlpm_pkg::OP_INSERT, 8'hE7, i == room - 1, 8'h3C);
    for (int i = 0; i < room + 3; i++)
      send_request(tlpm_pkg::OP_ROUTE, 8'hE7, i == room + 2, 8'h00);
    room = NODE_COUNT - nodes_taken + 8;
    for (int i = 0; i < room; i++)
      send_request(tlpm_pkg::OP_INSERT, 8'hE8, i == room - 1, 8'hC3);
    for (int i = 0; i < 4; i++)
      send_request(tlpm_pkg::OP_ROUTE, 8'hE8, i == 3, 8'h00);
    send_text(tlpm_pkg::OP_INSERT, "abcabcab", 8'h99);
  endtask

  task automatic test_random_after_full();
    int target;
    target = requests_sent + 80;
    while (requests_sent < target) begin
      if ($urandom_range(0, 19) == 0) stalls_on = ($urandom_range(0, 3) != 0);
      send_word(($urandom_range(0, 4) == 0) ? WORD_MIXED : WORD_PLAIN,
                $urandom_range(0, 1) == 1);
    end
  endtask

  always @(negedge clk) begin
    if (!stalls_on) begin
      out_ready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= ($urandom_range(0, 2) != 0);
      ready_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("result with no request pending: op_done %0d", op_done);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        if (op_done !== want.op_done) begin
          $error("op_done: expected %0d, actual %0d", want.op_done, op_done);
          mismatch_count++;
        end
        if (found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, found);
          mismatch_count++;
        end
        if (matched_length !== want.matched_length) begin
          $error("matched_length: expected %0d, actual %0d", want.matched_length,
                 matched_length);
          mismatch_count++;
        end
        if (agent_result !== want.agent_result) begin
          $error("agent_result: expected %0d, actual %0d", want.agent_result, agent_result);
          mismatch_count++;
        end
        if (table_full !== want.table_full) begin
          $error("table_full: expected %0d, actual %0d", want.table_full, table_full);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    operation = tlpm_pkg::OP_INSERT;
    character = '0;
    last      = 1'b0;
    agent_id  = '0;
    out_ready = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_words();
    test_pool_exhaustion();
    test_random_after_full();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> trie_longest_prefix_match.f
src/tlpm_pkg.sv
src/tlpm_ctrl.sv
src/tlpm_datapath.sv
src/trie_longest_prefix_match.sv
bench/trie_longest_prefix_match_tb.sv
